>>> src/scrt_pkg.sv
// Shared types, constants and codes of the segmented CAN receive tracker.
package scrt_pkg;

  localparam int MAX_SENDERS  = 8;
  localparam int MAX_FRAMES   = 16;

  localparam int ID_W         = 29;
  localparam int COUNT_W      = 14;
  localparam int TIMER_W      = 24;
  localparam int SLOT_W       = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int ENTRY_W      = ID_W + COUNT_W;
  localparam int SENDER_IDX_W = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;
  localparam int SENDER_CNT_W = $clog2(MAX_SENDERS + 1);
  localparam int FRAME_CNT_W  = $clog2(MAX_FRAMES + 1);

  localparam logic [3:0]         FT_FIRST       = 4'h1;
  localparam logic [3:0]         FT_CONSEC      = 4'h2;
  localparam logic [COUNT_W-1:0] FF_HEAD_BYTES  = 14'd6;
  localparam logic [COUNT_W:0]   CF_BYTES       = 15'd7;
  localparam logic [COUNT_W-1:0] COUNT_MIN      = 14'h2000;
  localparam logic [TIMER_W-1:0] RESP_TO_RESET  = 24'd50;
  localparam logic [TIMER_W-1:0] GAP_TO_RESET   = 24'd1000;

  typedef enum logic [1:0] {
    CMD_START     = 2'd0,
    CMD_TICK      = 2'd1,
    CMD_FRAME     = 2'd2,
    CMD_BUS_ERROR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_RUNNING     = 3'd0,
    OUT_NORMAL      = 3'd1,
    OUT_NO_RESPONSE = 3'd2,
    OUT_OVERFLOW    = 3'd3,
    OUT_BUS_ERROR   = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    SEG_NONE     = 2'd0,
    SEG_PENDING  = 2'd1,
    SEG_COMPLETE = 2'd2
  } seg_status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RESPONSE_TIMEOUT = 2'd0,
    CFG_GAP_TIMEOUT      = 2'd1,
    CFG_FIRST_ONLY       = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_COMPARE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    cmd_t          cmd;
    logic [ID_W-1:0] frame_id;
    logic [7:0]    pci_byte;
    logic [7:0]    length_low_byte;
    logic          rx_overflow;
  } in_item_t;

  typedef struct packed {
    logic              send_flow_control;
    logic              keep_frame;
    logic [SLOT_W-1:0] buffer_slot;
    logic              finished;
    outcome_t          outcome;
    seg_status_t       segment_status;
  } out_item_t;

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [TIMER_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic load;
    logic head;
    logic compare;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic search;
    logic match;
    logic last_entry;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/scrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scrt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/scrt_ctrl.sv
// Sequencer of the receive tracker: takes an item, runs the sender search when asked, emits the result.
module scrt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  scrt_pkg::dp_status_t status,
  output scrt_pkg::dp_cmd_t    cmd
);

  scrt_pkg::state_t state;
  scrt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scrt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      scrt_pkg::ST_IDLE: begin
        if (in_valid) state_next = scrt_pkg::ST_DECIDE;
      end
      scrt_pkg::ST_DECIDE: begin
        state_next = status.search ? scrt_pkg::ST_READ : scrt_pkg::ST_RESULT;
      end
      scrt_pkg::ST_READ: begin
        state_next = scrt_pkg::ST_COMPARE;
      end
      scrt_pkg::ST_COMPARE: begin
        if (status.match || status.last_entry) begin
          state_next = scrt_pkg::ST_RESULT;
        end else begin
          state_next = scrt_pkg::ST_READ;
        end
      end
      scrt_pkg::ST_RESULT: begin
        if (status.out_free) state_next = scrt_pkg::ST_IDLE;
      end
      default: state_next = scrt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd         = '0;
    unique case (state)
      scrt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      scrt_pkg::ST_DECIDE:  cmd.head    = 1'b1;
      scrt_pkg::ST_READ:    cmd         = '0;
      scrt_pkg::ST_COMPARE: cmd.compare = 1'b1;
      scrt_pkg::ST_RESULT:  cmd.finish  = status.out_free;
      default:              cmd         = '0;
    endcase
  end

  a_compare_after_read: assert property (@(posedge clk) disable iff (rst)
    state == scrt_pkg::ST_COMPARE |-> $past(state) == scrt_pkg::ST_READ)
    else $error("compare step without a preceding table read");

  a_accept_to_decide: assert property (@(posedge clk) disable iff (rst)
    (state == scrt_pkg::ST_IDLE && in_valid) |=> state == scrt_pkg::ST_DECIDE)
    else $error("accepted item did not enter the decide step");

  a_stall_while_busy: assert property (@(posedge clk) disable iff (rst)
    state != scrt_pkg::ST_IDLE |-> in_stall)
    else $error("input open while an item is in work");

endmodule

>>> src/scrt_dp.sv
// Datapath of the receive tracker: session state, sender table, timers and result register.
module scrt_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  scrt_pkg::in_item_t   in_data,
  input  scrt_pkg::cfg_wr_t    cfg_wr,
  input  scrt_pkg::dp_cmd_t    cmd,
  output scrt_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output scrt_pkg::out_item_t  out_data
);

  scrt_pkg::in_item_t                 item;
  logic [scrt_pkg::TIMER_W-1:0]       resp_to;
  logic [scrt_pkg::TIMER_W-1:0]       gap_to;
  logic                               first_only;
  logic [scrt_pkg::MAX_SENDERS-1:0]   pos;
  logic [scrt_pkg::SENDER_CNT_W-1:0]  recorded;
  logic [scrt_pkg::ID_W-1:0]          first_sender;
  logic [scrt_pkg::FRAME_CNT_W-1:0]   frames_kept;
  logic [scrt_pkg::TIMER_W-1:0]       reply_timer;
  logic [scrt_pkg::TIMER_W-1:0]       gap_timer;
  logic                               active;
  logic [scrt_pkg::SENDER_IDX_W-1:0]  idx;

  logic                               ram_we;
  logic [scrt_pkg::SENDER_IDX_W-1:0]  ram_waddr;
  logic [scrt_pkg::ENTRY_W-1:0]       ram_wdata;
  logic [scrt_pkg::ENTRY_W-1:0]       ram_rdata;

  logic [3:0]                         frame_type;
  logic                               frame_live;
  logic                               ff_record;
  logic [scrt_pkg::SENDER_IDX_W-1:0]  rec_idx;
  logic [11:0]                        ff_len;
  logic [scrt_pkg::COUNT_W-1:0]       ff_count;
  logic                               match;
  logic [scrt_pkg::COUNT_W:0]         cf_dec;
  logic [scrt_pkg::COUNT_W-1:0]       cf_count;
  logic                               cf_pos;
  logic                               any_pending;
  scrt_pkg::seg_status_t              seg;
  logic [scrt_pkg::TIMER_W-1:0]       reply_inc;
  logic [scrt_pkg::TIMER_W-1:0]       gap_inc;
  logic [scrt_pkg::FRAME_CNT_W-1:0]   fk_inc;
  logic [scrt_pkg::FRAME_CNT_W-1:0]   fk_after;
  logic                               keep;
  logic                               fin;
  scrt_pkg::out_item_t                res;

  scrt_ram #(
    .WIDTH (scrt_pkg::ENTRY_W),
    .DEPTH (scrt_pkg::MAX_SENDERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Frame decode and table update values.
  assign frame_type = item.pci_byte[7:4];
  assign frame_live = active && item.cmd == scrt_pkg::CMD_FRAME && !item.rx_overflow;
  assign ff_record  = frame_live && frame_type == scrt_pkg::FT_FIRST &&
                      recorded < scrt_pkg::SENDER_CNT_W'(scrt_pkg::MAX_SENDERS);
  assign rec_idx    = scrt_pkg::SENDER_IDX_W'(recorded);
  assign ff_len     = {item.pci_byte[3:0], item.length_low_byte};
  assign ff_count   = {2'b00, ff_len} - scrt_pkg::FF_HEAD_BYTES;

  assign match    = ram_rdata[scrt_pkg::ENTRY_W-1 -: scrt_pkg::ID_W] == item.frame_id;
  assign cf_dec   = {ram_rdata[scrt_pkg::COUNT_W-1], ram_rdata[scrt_pkg::COUNT_W-1:0]}
                    - scrt_pkg::CF_BYTES;
  // Saturate at the most negative count.
  assign cf_count = (cf_dec[scrt_pkg::COUNT_W] != cf_dec[scrt_pkg::COUNT_W-1]) ?
                    scrt_pkg::COUNT_MIN : cf_dec[scrt_pkg::COUNT_W-1:0];
  assign cf_pos   = !cf_count[scrt_pkg::COUNT_W-1] && (cf_count != '0);

  assign ram_we    = (cmd.head && ff_record) || (cmd.compare && match);
  assign ram_waddr = cmd.head ? rec_idx : idx;
  assign ram_wdata = cmd.head ? {item.frame_id, ff_count}
                              : {item.frame_id, cf_count};

  always_comb begin
    any_pending = 1'b0;
    for (int i = 0; i < scrt_pkg::MAX_SENDERS; i++) begin
      if (pos[i] && scrt_pkg::SENDER_CNT_W'(i) < recorded) any_pending = 1'b1;
    end
  end

  assign seg = (recorded == '0) ? scrt_pkg::SEG_NONE :
               (any_pending ? scrt_pkg::SEG_PENDING : scrt_pkg::SEG_COMPLETE);

  assign reply_inc = (reply_timer == '1) ? reply_timer
                                         : reply_timer + scrt_pkg::TIMER_W'(1);
  assign gap_inc   = (gap_timer == '1) ? gap_timer : gap_timer + scrt_pkg::TIMER_W'(1);
  assign fk_inc    = frames_kept + scrt_pkg::FRAME_CNT_W'(1);

  // Result of the item, formed from the state after table updates.
  always_comb begin
    res                = '0;
    res.segment_status = seg;
    keep               = 1'b0;
    fin                = 1'b0;
    fk_after           = frames_kept;
    if (active) begin
      unique case (item.cmd)
        scrt_pkg::CMD_START: begin
          fin = 1'b0;
        end
        scrt_pkg::CMD_BUS_ERROR: begin
          fin         = 1'b1;
          res.outcome = scrt_pkg::OUT_BUS_ERROR;
        end
        scrt_pkg::CMD_TICK: begin
          if ((seg != scrt_pkg::SEG_PENDING && reply_inc > resp_to) ||
              (seg == scrt_pkg::SEG_PENDING && gap_inc > gap_to)) begin
            fin         = 1'b1;
            res.outcome = (frames_kept == '0) ? scrt_pkg::OUT_NO_RESPONSE
                                              : scrt_pkg::OUT_NORMAL;
          end
        end
        scrt_pkg::CMD_FRAME: begin
          if (item.rx_overflow) begin
            fin         = 1'b1;
            res.outcome = scrt_pkg::OUT_OVERFLOW;
          end else begin
            res.send_flow_control = frame_type == scrt_pkg::FT_FIRST;
            keep = !(first_only && item.frame_id != first_sender);
            if (keep) begin
              res.keep_frame  = 1'b1;
              res.buffer_slot = scrt_pkg::SLOT_W'(frames_kept);
              fk_after        = fk_inc;
              if (fk_inc >= scrt_pkg::FRAME_CNT_W'(scrt_pkg::MAX_FRAMES) ||
                  (first_only && !pos[0])) begin
                fin         = 1'b1;
                res.outcome = scrt_pkg::OUT_NORMAL;
              end
            end
            // Gap timer restarts with the frame, so only the reply limit can expire.
            if (!fin && seg != scrt_pkg::SEG_PENDING && reply_timer > resp_to) begin
              fin         = 1'b1;
              res.outcome = (fk_after == '0) ? scrt_pkg::OUT_NO_RESPONSE
                                             : scrt_pkg::OUT_NORMAL;
            end
          end
        end
        default: fin = 1'b0;
      endcase
    end
    res.finished = fin;
  end

  assign status.search     = frame_live && frame_type == scrt_pkg::FT_CONSEC &&
                             recorded != '0;
  assign status.match      = match;
  assign status.last_entry = scrt_pkg::SENDER_CNT_W'(idx) + scrt_pkg::SENDER_CNT_W'(1)
                             >= recorded;
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_to      <= scrt_pkg::RESP_TO_RESET;
      gap_to       <= scrt_pkg::GAP_TO_RESET;
      first_only   <= 1'b0;
      pos          <= '0;
      recorded     <= '0;
      first_sender <= '0;
      frames_kept  <= '0;
      reply_timer  <= '0;
      gap_timer    <= '0;
      active       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          scrt_pkg::CFG_RESPONSE_TIMEOUT: resp_to    <= cfg_wr.data;
          scrt_pkg::CFG_GAP_TIMEOUT:      gap_to     <= cfg_wr.data;
          scrt_pkg::CFG_FIRST_ONLY:       first_only <= cfg_wr.data[0];
          default:                        first_only <= first_only;
        endcase
      end

      if (cmd.head) begin
        if (item.cmd == scrt_pkg::CMD_START) begin
          pos          <= '0;
          recorded     <= '0;
          first_sender <= '0;
          frames_kept  <= '0;
          reply_timer  <= '0;
          gap_timer    <= '0;
          active       <= 1'b1;
        end else if (frame_live) begin
          if (frames_kept == '0) first_sender <= item.frame_id;
          if (ff_record) begin
            pos[rec_idx] <= ff_len > 12'(scrt_pkg::FF_HEAD_BYTES);
            recorded     <= recorded + scrt_pkg::SENDER_CNT_W'(1);
          end
        end
      end

      if (cmd.compare && match) begin
        pos[idx] <= cf_pos;
      end

      if (cmd.finish) begin
        if (active && item.cmd == scrt_pkg::CMD_TICK) begin
          reply_timer <= reply_inc;
          gap_timer   <= gap_inc;
        end
        if (active && item.cmd == scrt_pkg::CMD_FRAME) begin
          gap_timer   <= '0;
          frames_kept <= fk_after;
        end
        if (fin) active <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.head) begin
      idx <= '0;
    end else if (cmd.compare && !match) begin
      idx <= idx + scrt_pkg::SENDER_IDX_W'(1);
    end
    if (cmd.finish) begin
      out_data <= res;
    end
  end

  a_recorded_bound: assert property (@(posedge clk) disable iff (rst)
    recorded <= scrt_pkg::SENDER_CNT_W'(scrt_pkg::MAX_SENDERS))
    else $error("sender count beyond table depth");

  a_buffer_open: assert property (@(posedge clk) disable iff (rst)
    active |-> frames_kept < scrt_pkg::FRAME_CNT_W'(scrt_pkg::MAX_FRAMES))
    else $error("session still open with a full buffer");

  a_outcome_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.finished == (out_data.outcome != scrt_pkg::OUT_RUNNING)))
    else $error("finished flag and outcome disagree");

endmodule

>>> src/segmented_can_receive_tracker.sv
// Top level of the segmented CAN receive tracker.
// Sequence: an item transfers in IDLE and passes DECIDE, then, for a consecutive frame, a
//   READ and a COMPARE per sender entry searched (up to MAX_SENDERS entries), then RESULT.
// The input stalls until the result is issued, so only one item is in work at a time;
//   the sender search reads one table entry at a time from a single RAM port.
// Reset (rst, synchronous): idle, no session, timeouts 50 / 1000 ticks, first-only off.
module segmented_can_receive_tracker (
  input  logic                               clk,
  input  logic                               rst,
  // Item input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  scrt_pkg::in_item_t                 in_data,
  // Result output channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output scrt_pkg::out_item_t                out_data,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [scrt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [scrt_pkg::TIMER_W-1:0]       cfg_data
);

  scrt_pkg::dp_cmd_t    cmd;
  scrt_pkg::dp_status_t status;
  scrt_pkg::cfg_wr_t    cfg_wr;

  // Writes always land; the user keeps the block idle while they arrive (unchecked).
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // Controller: hold the input while an item is in work, step the sender search,
  // and issue the result once the output register can take a transfer.
  scrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: session state, sender table RAM, timers and the output register,
  // which decouples result delivery from the next input transfer.
  scrt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_wr    (cfg_wr),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> dv/segmented_can_receive_tracker_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the segmented CAN receive tracker, with a reply scoreboard.
module segmented_can_receive_tracker_tb;
  import scrt_pkg::*;

  // Scoreboard: tracks the receive session alongside the block and holds the
  // replies the block owes, in transfer order.
  class rx_session_scoreboard;
    logic [TIMER_W-1:0]        reply_limit;
    logic [TIMER_W-1:0]        gap_limit;
    logic                      first_only;
    logic [ID_W-1:0]           ids [MAX_SENDERS];
    logic signed [COUNT_W-1:0] remaining [MAX_SENDERS];
    int                        recorded;
    int                        kept;
    logic [ID_W-1:0]           first_id;
    logic [TIMER_W-1:0]        reply_t;
    logic [TIMER_W-1:0]        gap_t;
    bit                        active;
    out_item_t                 expected_replies [$];
    int                        failures;
    int                        reported;
    int                        checked;
    int                        ends [5];

    function new();
      reply_limit = RESP_TO_RESET;
      gap_limit   = GAP_TO_RESET;
      first_only  = 1'b0;
      recorded    = 0;
      kept        = 0;
      first_id    = '0;
      reply_t     = '0;
      gap_t       = '0;
      active      = 1'b0;
      failures    = 0;
      reported    = 0;
      checked     = 0;
      foreach (ends[i]) ends[i] = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [TIMER_W-1:0] val);
      case (idx)
        CFG_RESPONSE_TIMEOUT: reply_limit = val;
        CFG_GAP_TIMEOUT:      gap_limit   = val;
        CFG_FIRST_ONLY:       first_only  = val[0];
        default: ;
      endcase
    endfunction

    // Pending while any recorded sender still owes bytes.
    function seg_status_t seg_state();
      int i;
      if (recorded == 0) return SEG_NONE;
      for (i = 0; i < recorded; i++)
        if (remaining[i] > 0) return SEG_PENDING;
      return SEG_COMPLETE;
    endfunction

    function bit timer_expired();
      if (seg_state() == SEG_PENDING) return gap_t > gap_limit;
      return reply_t > reply_limit;
    endfunction

    // Advance the session by one accepted item and queue the reply it owes.
    function void track_event(in_item_t it);
      out_item_t r;
      int        count;
      int        i;
      r = '0;
      if (it.cmd == CMD_START) begin
        recorded     = 0;
        remaining[0] = '0;
        first_id     = '0;
        kept         = 0;
        reply_t      = '0;
        gap_t        = '0;
        active       = 1'b1;
      end else if (active) begin
        case (it.cmd)
          CMD_BUS_ERROR: begin
            r.finished = 1'b1;
            r.outcome  = OUT_BUS_ERROR;
          end
          CMD_TICK: begin
            if (reply_t != '1) reply_t = reply_t + 1'b1;
            if (gap_t != '1) gap_t = gap_t + 1'b1;
            if (timer_expired()) begin
              r.finished = 1'b1;
              r.outcome  = (kept == 0) ? OUT_NO_RESPONSE : OUT_NORMAL;
            end
          end
          default: begin
            gap_t = '0;
            if (it.rx_overflow) begin
              r.finished = 1'b1;
              r.outcome  = OUT_OVERFLOW;
            end else begin
              if (kept == 0) first_id = it.frame_id;
              if (it.pci_byte[7:4] == FT_FIRST) begin
                r.send_flow_control = 1'b1;
                // A full table still grants flow control but records nothing.
                if (recorded < MAX_SENDERS) begin
                  count = int'({it.pci_byte[3:0], it.length_low_byte}) - int'(FF_HEAD_BYTES);
                  remaining[recorded] = count[COUNT_W-1:0];
                  ids[recorded]       = it.frame_id;
                  recorded++;
                end
              end else if (it.pci_byte[7:4] == FT_CONSEC) begin
                for (i = 0; i < recorded; i++) begin
                  if (ids[i] == it.frame_id) begin
                    count = int'(remaining[i]) - int'(CF_BYTES);
                    if (count < -(1 << (COUNT_W - 1))) count = -(1 << (COUNT_W - 1));
                    remaining[i] = count[COUNT_W-1:0];
                    break;
                  end
                end
              end
              if (!(first_only && it.frame_id != first_id)) begin
                r.keep_frame  = 1'b1;
                r.buffer_slot = kept[SLOT_W-1:0];
                kept++;
                if (kept >= MAX_FRAMES || (first_only && remaining[0] <= 0)) begin
                  r.finished = 1'b1;
                  r.outcome  = OUT_NORMAL;
                end
              end
              if (!r.finished && timer_expired()) begin
                r.finished = 1'b1;
                r.outcome  = (kept == 0) ? OUT_NO_RESPONSE : OUT_NORMAL;
              end
            end
          end
        endcase
      end
      if (r.finished) begin
        active = 1'b0;
        ends[r.outcome]++;
      end
      r.segment_status = seg_state();
      expected_replies.push_back(r);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      bit        bad;
      checked++;
      if (expected_replies.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] reply %0d arrived with nothing outstanding", $realtime, checked);
        end
        return;
      end
      want = expected_replies.pop_front();
      bad  = (got.send_flow_control !== want.send_flow_control) ||
             (got.keep_frame        !== want.keep_frame)        ||
             (got.buffer_slot       !== want.buffer_slot)       ||
             (got.finished          !== want.finished)          ||
             (got.outcome           !== want.outcome)           ||
             (got.segment_status    !== want.segment_status);
      if (bad) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] reply %0d mismatch: fc/keep/slot/fin/outcome/seg", $realtime, checked);
          $display("  exp %0b %0b %0d %0b %0d %0d", want.send_flow_control, want.keep_frame,
                   want.buffer_slot, want.finished, want.outcome, want.segment_status);
          $display("  got %0b %0b %0d %0b %0d %0d", got.send_flow_control, got.keep_frame,
                   got.buffer_slot, got.finished, got.outcome, got.segment_status);
        end
      end
    endfunction

    function void close_out();
      if (expected_replies.size() != 0) begin
        failures += expected_replies.size();
        $display("%0d replies never arrived", expected_replies.size());
      end
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [TIMER_W-1:0]     cfg_data  = '0;

  in_item_t             bus_events_q [$];  // items waiting to be offered to the block
  int                   items_queued   = 0;
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;
  rx_session_scoreboard board = new();

  segmented_can_receive_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Input side: note each transfer, then either offer the next item or go idle.
  // A stalled item is held untouched until it transfers.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) board.track_event(in_data);
      if (!in_valid || !in_stall) begin
        if (bus_events_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= bus_events_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: check every reply transfer and stall at the phase's rate.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_reply(out_data);
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic queue_item(cmd_t c, logic [ID_W-1:0] id, logic [7:0] pci, logic [7:0] len,
                            logic ovf);
    in_item_t it;
    it.cmd             = c;
    it.frame_id        = id;
    it.pci_byte        = pci;
    it.length_low_byte = len;
    it.rx_overflow     = ovf;
    bus_events_q.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(cfg_index_t idx, logic [TIMER_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic set_registers(logic [TIMER_W-1:0] resp, logic [TIMER_W-1:0] gap, logic fonly);
    write_reg(CFG_RESPONSE_TIMEOUT, resp);
    write_reg(CFG_GAP_TIMEOUT, gap);
    write_reg(CFG_FIRST_ONLY, {{(TIMER_W-1){1'b0}}, fonly});
  endtask

  // Hold until every item has transferred and every reply is back, then let
  // the worst-case search time pass so the block is truly idle.
  task automatic quiesce();
    while (bus_events_q.size() != 0 || in_valid || board.expected_replies.size() != 0)
      @(posedge clk);
    repeat (3 + 2 * MAX_SENDERS + 8) @(posedge clk);
  endtask

  // One session: start, optional burst of first frames to fill the sender
  // table, then a mix dominated by well-formed traffic from a small sender pool.
  task automatic queue_session();
    logic [ID_W-1:0] pool [10];
    int              n_pool;
    int              n_steps;
    int              pick;
    int              who;
    int              i;
    logic [3:0]      nib;
    n_pool = ($urandom_range(7) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 3);
    for (i = 0; i < n_pool; i++)
      pool[i] = ID_W'(($urandom_range(1) == 1) ? $urandom : $urandom_range(2047));
    queue_item(CMD_START, ID_W'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    if (n_pool > 3)
      for (i = 0; i < n_pool; i++)
        queue_item(CMD_FRAME, pool[i], {FT_FIRST, 4'h0}, 8'($urandom_range(8, 60)), 1'b0);
    n_steps = $urandom_range(4, 24);
    for (i = 0; i < n_steps; i++) begin
      who  = $urandom_range(n_pool - 1);
      nib  = 4'($urandom);
      pick = $urandom_range(99);
      if (pick < 40) begin
        queue_item(CMD_FRAME, pool[who], {FT_CONSEC, nib}, 8'($urandom), 1'b0);
      end else if (pick < 55) begin
        // Mostly short messages so counts actually run out.
        if ($urandom_range(3) != 0)
          queue_item(CMD_FRAME, pool[who], {FT_FIRST, 4'h0}, 8'($urandom_range(60)), 1'b0);
        else
          queue_item(CMD_FRAME, pool[who], {FT_FIRST, nib}, 8'($urandom), 1'b0);
      end else if (pick < 75) begin
        queue_item(CMD_TICK, ID_W'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 83) begin
        queue_item(CMD_FRAME, ID_W'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      end else if (pick < 90) begin
        while (nib == FT_FIRST || nib == FT_CONSEC) nib = 4'($urandom);
        queue_item(CMD_FRAME, pool[who], {nib, nib}, 8'($urandom), 1'b0);
      end else if (pick < 93) begin
        queue_item(CMD_FRAME, pool[who], 8'($urandom), 8'($urandom), 1'b1);
      end else if (pick < 96) begin
        queue_item(CMD_BUS_ERROR, ID_W'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        queue_item(CMD_START, ID_W'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int                 ph;
    int                 mark;
    logic [TIMER_W-1:0] rlim;
    logic [TIMER_W-1:0] glim;
    logic               fonly;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset register values: idle session, field extremes, first, consecutive
    // and other frame types, overflow, bus error and restart.
    queue_item(CMD_TICK, '1, 8'hFF, 8'hFF, 1'b1);
    queue_item(CMD_FRAME, '1, 8'h10, 8'h20, 1'b0);
    queue_item(CMD_BUS_ERROR, '0, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_START, '0, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_FRAME, '1, 8'h1F, 8'hFF, 1'b0);
    queue_item(CMD_FRAME, '1, 8'h2F, 8'hFF, 1'b0);
    queue_item(CMD_FRAME, '0, 8'h20, 8'h00, 1'b0);
    queue_item(CMD_FRAME, 29'h7FF, 8'hF0, 8'h55, 1'b0);
    queue_item(CMD_FRAME, '0, 8'h10, 8'h00, 1'b0);
    queue_item(CMD_FRAME, 29'h0ABCDEF, 8'h10, 8'h0D, 1'b0);
    queue_item(CMD_FRAME, 29'h123, 8'h21, 8'hAA, 1'b1);
    queue_item(CMD_FRAME, 29'h123, 8'h10, 8'h10, 1'b0);
    queue_item(CMD_START, '1, 8'hFF, 8'hFF, 1'b1);
    queue_item(CMD_BUS_ERROR, '1, 8'hFF, 8'hFF, 1'b1);
    queue_item(CMD_START, '0, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_START, '0, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_FRAME, 29'h7E8, 8'h10, 8'h06, 1'b0);
    quiesce();

    // Directed, short timeouts: no-response end, then gap timeout while pending.
    set_registers(24'd2, 24'd3, 1'b0);
    queue_item(CMD_START, '0, 8'h00, 8'h00, 1'b0);
    repeat (3) queue_item(CMD_TICK, '0, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_START, '0, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_FRAME, 29'h7E8, 8'h10, 8'h40, 1'b0);
    repeat (4) queue_item(CMD_TICK, '0, 8'h00, 8'h00, 1'b0);

    // Random phases: rotate register settings (extremes included) and idle patterns.
    for (ph = 1; ph <= 9; ph++) begin
      quiesce();
      case (ph)
        1: begin rlim = '0;  glim = '0;  fonly = 1'b0; end
        2: begin rlim = '1;  glim = '1;  fonly = 1'b1; end
        3: begin rlim = TIMER_W'(50); glim = TIMER_W'(1000); fonly = 1'b0; end
        4: begin
          rlim  = TIMER_W'($urandom_range(1, 8));
          glim  = TIMER_W'($urandom_range(1, 12));
          fonly = 1'b1;
        end
        5: begin
          rlim  = TIMER_W'($urandom_range(6));
          glim  = TIMER_W'($urandom_range(10));
          fonly = 1'b0;
        end
        6: begin rlim = '1;  glim = '0;  fonly = 1'b0; end
        7: begin rlim = TIMER_W'(4); glim = TIMER_W'(6); fonly = 1'b1; end
        8: begin
          rlim  = TIMER_W'($urandom_range(1, 30));
          glim  = TIMER_W'($urandom_range(1, 30));
          fonly = 1'($urandom_range(1));
        end
        default: begin rlim = '0; glim = '1; fonly = 1'b1; end
      endcase
      set_registers(rlim, glim, fonly);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      mark = items_queued;
      while (items_queued - mark < 60) queue_session();
    end

    // Drain, let the block settle, then account for anything still owed.
    quiesce();
    board.close_out();
    $display("Checked %0d replies to %0d items across ten register settings and four idle mixes.",
             board.checked, items_queued);
    $display("Sessions closed: normal %0d, no response %0d, overflow %0d, bus error %0d.",
             board.ends[OUT_NORMAL], board.ends[OUT_NO_RESPONSE], board.ends[OUT_OVERFLOW],
             board.ends[OUT_BUS_ERROR]);
    if (board.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> segmented_can_receive_tracker.f
src/scrt_pkg.sv
src/scrt_ram.sv
src/scrt_ctrl.sv
src/scrt_dp.sv
src/segmented_can_receive_tracker.sv
dv/segmented_can_receive_tracker_tb.sv
